// ----- design/apsd_pkg.sv -----
package apsd_pkg;

   // input word: one IMU sample
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [15:0]        gyro_magnitude;
      logic [47:0]        timestamp_us;
   } req_word_type;

   // result word: step flag, counts and walking state
   typedef struct packed {
      logic        step_detected;
      logic [31:0] total_steps;
      logic [7:0]  session_steps;
      logic        walking;
   } rsp_word_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic       load;
      logic       sq_step;
      logic [1:0] sq_sel;
      logic       sq_last;
      logic       root_step;
      logic       mul;
      logic       add;
      logic       hp;
      logic       decide;
   } cmd_type;

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_ARM   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PEAK   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GYRO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IVL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IVL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TO    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_WALK   = 3'd6;

   localparam logic [15:0] RST_PEAK_ARM = 16'd410;
   localparam logic [15:0] RST_MIN_PEAK = 16'd614;
   localparam logic [15:0] RST_MIN_GYRO = 16'd160;
   localparam logic [23:0] RST_MIN_IVL  = 24'd250000;
   localparam logic [23:0] RST_MAX_IVL  = 24'd2000000;
   localparam logic [23:0] RST_IDLE_TO  = 24'd3000000;
   localparam logic [7:0]  RST_MIN_WALK = 8'd4;

   // filter constants: alpha about 0.035 in Q.16, 1.0 g in Q8.16
   localparam logic [12:0] ALPHA_Q16 = 13'd2294;
   localparam logic [23:0] ONE_G_Q16 = 24'd65536;
   localparam logic [23:0] AVG_MAX   = 24'hFFFFFF;
   localparam logic [7:0]  SESSION_MAX = 8'hFF;

   // iteration counts
   localparam int SQ_STEPS   = 3;
   localparam int ROOT_STEPS = 20;
   localparam int CNT_W      = 5;

endpackage

// ----- design/apsd_ctrl.sv -----
module apsd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apsd_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQ   = 3'd1;
   localparam logic [2:0] S_ROOT = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_HP   = 3'd5;
   localparam logic [2:0] S_DEC  = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [apsd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         out_free;
   logic                         accept;

   // the result slot is free when it is empty or when the held word leaves this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_SQ;
               cnt_in   = '0;
            end
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            cmd.sq_sel  = cnt_ff[1:0];
            if (cnt_ff == apsd_pkg::CNT_W'(apsd_pkg::SQ_STEPS - 1)) begin
               cmd.sq_last = 1'b1;
               state_in    = S_ROOT;
               cnt_in      = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (cnt_ff == apsd_pkg::CNT_W'(apsd_pkg::ROOT_STEPS - 1)) begin
               state_in = S_MUL;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_HP;
         end
         S_HP: begin
            cmd.hp   = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            // commit only when the result register can take the word
            if (out_free) begin
               cmd.decide = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   // result valid
   always_comb begin
      if (cmd.decide) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_SQ)
      else $error("accepted word did not start the square phase");

   a_decide_free: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result committed over a held word");

   a_decide_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> rsp_valid_ff)
      else $error("committed result not presented");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROOT |-> cnt_ff < apsd_pkg::CNT_W'(apsd_pkg::ROOT_STEPS))
      else $error("root iteration count out of range");

endmodule

// ----- design/apsd_dp.sv -----
module apsd_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  apsd_pkg::cmd_type                 cmd,
   input  apsd_pkg::req_word_type            req_word,
   output apsd_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_we,
   input  logic [apsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration
   logic [15:0] peak_arm_ff, min_peak_ff, min_gyro_ff;
   logic [23:0] min_ivl_ff, max_ivl_ff, idle_to_ff;
   logic [7:0]  min_walk_ff;

   // captured sample
   apsd_pkg::req_word_type smp_ff;

   // magnitude path
   logic [31:0]        acc_ff, acc_sum;
   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   logic [39:0]        op_ff, op_in;
   logic [21:0]        rem_ff, rem_in;
   logic [19:0]        root_ff, root_in;
   logic [23:0]        rem_t, trial;

   // average and high-pass
   logic signed [38:0] prod_ff, prod_in, diff_w, rnd_sum;
   logic signed [25:0] diff, new_avg, delta_w, hp_in, hp_ff;
   logic signed [22:0] delta;
   logic [23:0]        avg_ff, avg_in;

   // interval flags
   logic [47:0] el;
   logic        ge_min_ff, le_max_ff, gt_to_ff;

   // detector state
   logic signed [25:0] prev_hp_ff;
   logic        armed_ff, cad_ff, walk_ff;
   logic [47:0] last_ff;
   logic [31:0] total_ff;
   logic [7:0]  sess_ff;

   // decision
   logic        arm_cond, armed_now, cand, step, upd;
   logic        armed_n, cad_n, walk_n;
   logic [47:0] last_n;
   logic [31:0] total_n;
   logic [7:0]  sess_n;

   apsd_pkg::rsp_word_type rsp_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         peak_arm_ff <= apsd_pkg::RST_PEAK_ARM;
         min_peak_ff <= apsd_pkg::RST_MIN_PEAK;
         min_gyro_ff <= apsd_pkg::RST_MIN_GYRO;
         min_ivl_ff  <= apsd_pkg::RST_MIN_IVL;
         max_ivl_ff  <= apsd_pkg::RST_MAX_IVL;
         idle_to_ff  <= apsd_pkg::RST_IDLE_TO;
         min_walk_ff <= apsd_pkg::RST_MIN_WALK;
      end else if (csr_we) begin
         case (csr_index)
            apsd_pkg::CSR_PEAK_ARM: peak_arm_ff <= csr_wdata[15:0];
            apsd_pkg::CSR_MIN_PEAK: min_peak_ff <= csr_wdata[15:0];
            apsd_pkg::CSR_MIN_GYRO: min_gyro_ff <= csr_wdata[15:0];
            apsd_pkg::CSR_MIN_IVL:  min_ivl_ff  <= csr_wdata;
            apsd_pkg::CSR_MAX_IVL:  max_ivl_ff  <= csr_wdata;
            apsd_pkg::CSR_IDLE_TO:  idle_to_ff  <= csr_wdata;
            apsd_pkg::CSR_MIN_WALK: min_walk_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // one shared squarer, one axis per cycle
   always_comb begin
      case (cmd.sq_sel)
         2'd0:    sq_op = smp_ff.accel_x;
         2'd1:    sq_op = smp_ff.accel_y;
         default: sq_op = smp_ff.accel_z;
      endcase
   end
   assign sq_prod = sq_op * sq_op;
   assign acc_sum = acc_ff + 32'(unsigned'(sq_prod));

   // digit-by-digit square root, two radicand bits per step
   assign rem_t = {rem_ff, op_ff[39:38]};
   assign trial = {2'b00, root_ff, 2'b01};
   always_comb begin
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sq_last) begin
         op_in   = {acc_sum, 8'd0};
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.root_step) begin
         op_in = {op_ff[37:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in  = 22'(rem_t - trial);
            root_in = {root_ff[18:0], 1'b1};
         end else begin
            rem_in  = rem_t[21:0];
            root_in = {root_ff[18:0], 1'b0};
         end
      end
   end

   // average update: alpha * (mag - avg), rounded, floor shift, clamped
   assign diff    = $signed({6'd0, root_ff}) - $signed({2'd0, avg_ff});
   assign diff_w  = 39'(diff);
   assign prod_in = diff_w * $signed({26'd0, apsd_pkg::ALPHA_Q16});
   assign rnd_sum = prod_ff + 39'sd32768;
   assign delta   = rnd_sum[38:16];
   assign delta_w = 26'(delta);
   assign new_avg = $signed({2'd0, avg_ff}) + delta_w;
   always_comb begin
      if (new_avg < 26'sd0) begin
         avg_in = '0;
      end else if (new_avg > $signed({2'd0, apsd_pkg::AVG_MAX})) begin
         avg_in = apsd_pkg::AVG_MAX;
      end else begin
         avg_in = new_avg[23:0];
      end
   end

   // high-pass value and time since last step
   assign hp_in = $signed({6'd0, root_ff}) - $signed({2'd0, avg_ff});
   assign el    = (smp_ff.timestamp_us >= last_ff) ? (smp_ff.timestamp_us - last_ff) : 48'd0;

   // peak detector and cadence logic
   always_comb begin
      arm_cond  = (hp_ff > $signed({6'd0, peak_arm_ff, 4'd0})) && (hp_ff >= prev_hp_ff);
      armed_now = armed_ff || arm_cond;
      cand      = armed_now && (hp_ff < prev_hp_ff)
                  && (prev_hp_ff >= $signed({6'd0, min_peak_ff, 4'd0}))
                  && (smp_ff.gyro_magnitude >= min_gyro_ff);
      step    = 1'b0;
      upd     = 1'b0;
      armed_n = armed_now;
      cad_n   = cad_ff;
      walk_n  = walk_ff;
      last_n  = last_ff;
      total_n = total_ff;
      sess_n  = sess_ff;
      if (cand) begin
         armed_n = 1'b0;
         if (!cad_ff) begin
            cad_n  = 1'b1;
            last_n = smp_ff.timestamp_us;
            upd    = 1'b1;
         end else if (ge_min_ff && le_max_ff) begin
            step = 1'b1;
         end else if (!le_max_ff) begin
            // too long a gap: restart the session
            last_n = smp_ff.timestamp_us;
            upd    = 1'b1;
            sess_n = '0;
            walk_n = 1'b0;
         end
      end
      if (step) begin
         total_n = total_ff + 1'b1;
         if (sess_ff != apsd_pkg::SESSION_MAX) begin
            sess_n = sess_ff + 1'b1;
         end
         last_n = smp_ff.timestamp_us;
         upd    = 1'b1;
         if (sess_n >= min_walk_ff) begin
            walk_n = 1'b1;
         end
      end
      // idle check; a fresh last-step time means zero idle time
      if (last_n == 48'd0) begin
         walk_n = 1'b0;
      end else if (!upd && gt_to_ff) begin
         walk_n  = 1'b0;
         sess_n  = '0;
         total_n = '0;
         cad_n   = 1'b0;
         last_n  = '0;
         armed_n = 1'b0;
      end
   end

   // payload registers of the working path
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff <= req_word;
         acc_ff <= '0;
      end else if (cmd.sq_step) begin
         acc_ff <= acc_sum;
      end
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.hp) begin
         hp_ff     <= hp_in;
         ge_min_ff <= (el >= {24'd0, min_ivl_ff});
         le_max_ff <= (el <= {24'd0, max_ivl_ff});
         gt_to_ff  <= (el > {24'd0, idle_to_ff});
      end
      if (cmd.decide) begin
         rsp_ff.step_detected <= step;
         rsp_ff.total_steps   <= total_n;
         rsp_ff.session_steps <= sess_n;
         rsp_ff.walking       <= walk_n;
      end
   end

   // detector state
   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff     <= apsd_pkg::ONE_G_Q16;
         prev_hp_ff <= '0;
         armed_ff   <= 1'b0;
         cad_ff     <= 1'b0;
         walk_ff    <= 1'b0;
         last_ff    <= '0;
         total_ff   <= '0;
         sess_ff    <= '0;
      end else begin
         if (cmd.add) begin
            avg_ff <= avg_in;
         end
         if (cmd.decide) begin
            prev_hp_ff <= hp_ff;
            armed_ff   <= armed_n;
            cad_ff     <= cad_n;
            walk_ff    <= walk_n;
            last_ff    <= last_n;
            total_ff   <= total_n;
            sess_ff    <= sess_n;
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// ----- design/accel_peak_step_detector.sv -----
// Peak-detection step counter, one IMU sample word in, one result word out.
// The sequence runs from accept to result valid: axis squares on one shared
// multiplier, 20 square-root iterations, then filter multiply, add, high-pass, decide.
// Words do not overlap: a new word is accepted only after the previous one is decided.
// A finished result waits in an output register while the next word is taken;
// a result still held there delays the decide step. Reset (synchronous, active high)
// restores register defaults and the 1.0 g average.
module accel_peak_step_detector (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  apsd_pkg::req_word_type            req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output apsd_pkg::rsp_word_type            rsp_word,
   input  logic                              csr_we,
   input  logic [apsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [apsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   apsd_pkg::cmd_type cmd;

   // sequencer
   apsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic, detector state and registers
   apsd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_word  (req_word),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule
